[sv/bss_pkg.sv]
package bss_pkg;

	localparam int DATA_W  = 8;
	localparam int LEN_W   = 14;
	localparam int IDX_W   = 15;
	localparam int SUM_W   = 16;
	localparam int ADDR_IN_W = 13;
	localparam int PHC_W   = 3;
	localparam int CFG_IDX_W = 2;

	localparam int FIFO_DEPTH = 8;
	localparam int FPTR_W     = 3;
	localparam int FCNT_W     = 4;

	localparam logic [DATA_W-1:0] MIDSCALE  = 8'h80;
	localparam logic [DATA_W-1:0] IDLE_DUTY = 8'h7F;
	localparam logic [DATA_W-1:0] VOL_MAX   = 8'hFF;
	localparam logic [15:0]       ROUND_ADD = 16'd127;
	localparam logic [6:0]        DECAY_MASK_ZERO = 7'd0;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_START_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_LEN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_VOL   = 2'd3;

	localparam logic [LEN_W-1:0]  START_LEN_RST  = 14'd1;
	localparam logic [LEN_W-1:0]  MIDDLE_LEN_RST = 14'd1;
	localparam logic [LEN_W-1:0]  END_LEN_RST    = 14'd2;
	localparam logic [DATA_W-1:0] STOP_VOL_RST   = 8'd32;

	localparam logic [PHC_W-1:0] PHC_START   = 3'd0;
	localparam logic [PHC_W-1:0] PHC_MIDDLE  = 3'd1;
	localparam logic [PHC_W-1:0] PHC_END     = 3'd2;
	localparam logic [PHC_W-1:0] PHC_REVERSE = 3'd3;
	localparam logic [PHC_W-1:0] PHC_FORWARD = 3'd4;
	localparam logic [PHC_W-1:0] PHC_STOPPED = 3'd5;

	typedef enum logic [5:0] {
		PH_START   = 6'b000001,
		PH_MIDDLE  = 6'b000010,
		PH_END     = 6'b000100,
		PH_REVERSE = 6'b001000,
		PH_FORWARD = 6'b010000,
		PH_STOPPED = 6'b100000
	} ph_t;

	typedef enum logic [1:0] {
		MODE_HOLD = 2'd0,
		MODE_PLAY = 2'd1,
		MODE_STOP = 2'd2
	} mode_t;

	typedef struct packed {
		logic              load;
		mode_t             mode;
		logic              use_mem;
		logic [DATA_W-1:0] vol;
		logic              running;
		logic [PHC_W-1:0]  phase;
		logic [DATA_W-1:0] wdata;
	} stg_t;

	typedef struct packed {
		logic [DATA_W-1:0] duty;
		logic              running;
		logic [PHC_W-1:0]  phase;
	} res_t;

	function automatic logic [PHC_W-1:0] ph_code(input ph_t ph);
		logic [PHC_W-1:0] c;
		unique case (ph)
			PH_START:   c = PHC_START;
			PH_MIDDLE:  c = PHC_MIDDLE;
			PH_END:     c = PHC_END;
			PH_REVERSE: c = PHC_REVERSE;
			PH_FORWARD: c = PHC_FORWARD;
			PH_STOPPED: c = PHC_STOPPED;
			default:    c = PHC_START;
		endcase
		return c;
	endfunction

endpackage

[sv/bell_sample_sequencer.sv]
// Bell sample sequencer. Each accepted tick word returns one result word (duty, running,
// phase) and, while play is high or a sequence runs, advances the start/middle/end/
// ping-pong sequence; each load word writes one sample and returns nothing. One word is
// accepted every cycle while in_ready is high. After acceptance the sample address is
// registered and multiplied by a reciprocal of SAMPLE_DEPTH. Next it is reduced modulo
// SAMPLE_DEPTH by a subtract and a correction, and the sample memory is read. Last the
// duty is scaled and the word is queued. The sample memory serves one load write or one
// tick read per cycle, in the reduction step. Results wait in an eight-word queue; input
// ready drops only when eight ticks are outstanding. Sample memory has no clearing pass:
// every entry must be loaded before a tick reads it.
module bell_sample_sequencer import bss_pkg::*; #(
	parameter int SAMPLE_DEPTH = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LEN_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic                  play,
	input  logic [ADDR_IN_W-1:0]  load_address,
	input  logic [DATA_W-1:0]     load_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     duty,
	output logic                  running,
	output logic [PHC_W-1:0]      phase
);

	localparam int AW      = $clog2(SAMPLE_DEPTH);
	localparam int QW      = SUM_W + 1 - AW;
	localparam int RECIP_W = 33 - AW;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / SAMPLE_DEPTH);
	localparam logic [SUM_W:0] DEPTH_W = (SUM_W+1)'(SAMPLE_DEPTH);

	logic [LEN_W-1:0]  start_len_q, middle_len_q, end_len_q;
	logic [DATA_W-1:0] stop_vol_q;

	ph_t               phase_q, phase_n;
	logic [IDX_W-1:0]  idx_q, idx_n;
	logic [DATA_W-1:0] vol_q, vol_n;
	logic [DATA_W-1:0] tmr_q, tmr_n;
	logic              active_q, active_n;
	logic [DATA_W-1:0] pending_q, current_q;

	logic              acc, tick;
	logic [IDX_W-1:0]  base, plus1, last_end, end_base;
	logic [DATA_W-1:0] tmr_inc, vol_dec;
	logic              use_mem;
	mode_t             mode;
	logic [SUM_W-1:0]  sum;
	stg_t              st_s0;

	logic              v_s1, v_s2, v_s3;
	stg_t              st_s1, st_s2, st_s3;
	logic [SUM_W-1:0]  sum_s1, sum_s2;
	logic [QW-1:0]     q_s2;
	logic [PROD_W-1:0] prod;

	logic [SUM_W:0]    qd, r0, r1;
	logic [AW-1:0]     mem_addr;
	logic [DATA_W-1:0] rdata;

	logic [DATA_W-1:0] data, mag, dd, scaled, duty_new;
	logic [15:0]       prod16;
	logic              up;

	res_t              fifo_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] fcnt_q, cnt_q;
	logic              push, pop;
	res_t              head;

	assign acc  = in_valid && in_ready;
	assign tick = acc && (command == CMD_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_len_q  <= START_LEN_RST;
			middle_len_q <= MIDDLE_LEN_RST;
			end_len_q    <= END_LEN_RST;
			stop_vol_q   <= STOP_VOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_LEN:  start_len_q  <= cfg_data;
				REG_MIDDLE_LEN: middle_len_q <= cfg_data;
				REG_END_LEN:    end_len_q    <= cfg_data;
				REG_STOP_VOL:   stop_vol_q   <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	assign plus1    = idx_q + IDX_W'(1);
	assign end_base = IDX_W'(start_len_q) + IDX_W'(middle_len_q);
	assign last_end = (end_len_q == '0) ? '0 : IDX_W'(end_len_q - LEN_W'(1));
	assign tmr_inc  = tmr_q + DATA_W'(1);
	assign vol_dec  = (tmr_inc[6:0] == DECAY_MASK_ZERO && vol_q != '0) ?
		vol_q - DATA_W'(1) : vol_q;

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		vol_n    = vol_q;
		tmr_n    = tmr_q;
		active_n = active_q | play;
		base     = '0;
		use_mem  = 1'b0;
		mode     = MODE_HOLD;
		if (active_q | play) begin
			mode    = MODE_PLAY;
			use_mem = 1'b1;
			unique case (phase_q)
				PH_START: begin
					idx_n = plus1;
					if (plus1 >= IDX_W'(start_len_q)) begin
						idx_n   = '0;
						phase_n = PH_MIDDLE;
					end
				end
				PH_MIDDLE: begin
					base  = IDX_W'(start_len_q);
					idx_n = plus1;
					if (plus1 >= IDX_W'(middle_len_q)) begin
						phase_n = PH_END;
					end
				end
				PH_END: begin
					base  = end_base;
					idx_n = plus1;
					if (plus1 >= IDX_W'(end_len_q)) begin
						idx_n   = last_end;
						phase_n = PH_REVERSE;
					end
				end
				PH_REVERSE: begin
					base  = end_base;
					tmr_n = tmr_inc;
					vol_n = vol_dec;
					if (idx_q == '0) begin
						idx_n   = IDX_W'(1);
						phase_n = (vol_dec < stop_vol_q) ? PH_STOPPED : PH_FORWARD;
					end else begin
						idx_n = idx_q - IDX_W'(1);
					end
				end
				PH_FORWARD: begin
					base  = end_base;
					tmr_n = tmr_inc;
					vol_n = vol_dec;
					idx_n = plus1;
					if (plus1 >= IDX_W'(end_len_q)) begin
						idx_n   = last_end;
						phase_n = (vol_dec < stop_vol_q) ? PH_STOPPED : PH_REVERSE;
					end
				end
				PH_STOPPED: begin
					mode    = MODE_STOP;
					use_mem = 1'b0;
					vol_n   = VOL_MAX;
					idx_n   = '0;
					if (!play) begin
						active_n = 1'b0;
						phase_n  = PH_START;
					end
				end
				default: begin
					phase_n = PH_START;
				end
			endcase
		end
	end

	assign sum = (command == CMD_LOAD) ? SUM_W'(load_address) : SUM_W'(base) + SUM_W'(idx_q);

	always_comb begin
		st_s0.load    = (command == CMD_LOAD);
		st_s0.mode    = mode;
		st_s0.use_mem = use_mem;
		st_s0.vol     = vol_n;
		st_s0.running = active_n;
		st_s0.phase   = ph_code(phase_n);
		st_s0.wdata   = load_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			idx_q    <= '0;
			vol_q    <= VOL_MAX;
			tmr_q    <= '0;
			active_q <= 1'b0;
		end else if (tick) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			vol_q    <= vol_n;
			tmr_q    <= tmr_n;
			active_q <= active_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign prod = PROD_W'(sum_s1) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		st_s1  <= st_s0;
		sum_s1 <= sum;
		st_s2  <= st_s1;
		sum_s2 <= sum_s1;
		q_s2   <= prod[32 +: QW];
		st_s3  <= st_s2;
	end

	assign qd       = (SUM_W+1)'(q_s2) * DEPTH_W;
	assign r0       = {1'b0, sum_s2} - qd;
	assign r1       = (r0 >= DEPTH_W) ? r0 - DEPTH_W : r0;
	assign mem_addr = r1[AW-1:0];

	bss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(SAMPLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (v_s2 && st_s2.load),
		.waddr(mem_addr),
		.wdata(st_s2.wdata),
		.re   (v_s2 && !st_s2.load && st_s2.use_mem),
		.raddr(mem_addr),
		.rdata(rdata)
	);

	assign data   = st_s3.use_mem ? rdata : IDLE_DUTY;
	assign up     = data > MIDSCALE;
	assign mag    = up ? data - MIDSCALE : MIDSCALE - data;
	assign prod16 = 16'(mag) * 16'(st_s3.vol) + ROUND_ADD;
	assign dd     = prod16[15:8];
	assign scaled = up ? MIDSCALE + dd : MIDSCALE - dd;

	always_comb begin
		unique case (st_s3.mode)
			MODE_PLAY: duty_new = pending_q;
			MODE_STOP: duty_new = IDLE_DUTY;
			default:   duty_new = current_q;
		endcase
	end

	assign push = v_s3 && !st_s3.load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= IDLE_DUTY;
			current_q <= IDLE_DUTY;
		end else if (push && st_s3.mode != MODE_HOLD) begin
			pending_q <= scaled;
			current_q <= duty_new;
		end
	end

	assign head      = fifo_q[rd_ptr_q];
	assign out_valid = (fcnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign in_ready  = (cnt_q != FCNT_W'(FIFO_DEPTH));
	assign duty      = head.duty;
	assign running   = head.running;
	assign phase     = head.phase;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{duty: duty_new, running: st_s3.running, phase: st_s3.phase};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			end
			fcnt_q <= fcnt_q + FCNT_W'(push) - FCNT_W'(pop);
			cnt_q  <= cnt_q + FCNT_W'(tick) - FCNT_W'(pop);
		end
	end

endmodule

[sv/bss_ram.sv]
module bss_ram import bss_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
